@@ rtl/bsfr_pkg.sv @@
package bsfr_pkg;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_GOOD     = 2'd0;
   localparam status_type ST_BADSUM   = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_FLAG   = 2'd0;
   localparam logic [1:0] CSR_ESCAPE = 2'd1;
   localparam logic [1:0] CSR_UNMASK = 2'd2;

   // register reset values
   localparam logic [7:0] FLAG_RESET   = 8'd126;
   localparam logic [7:0] ESCAPE_RESET = 8'd125;
   localparam logic [7:0] UNMASK_RESET = 8'd32;

   // controller -> datapath
   typedef struct packed {
      logic       take;        // input item accepted this cycle
      logic       emit_start;  // good frame closed, arm the read pointer
      logic       fetch;       // read buffer at read pointer
      logic       advance;     // step read pointer
      logic       load_data;   // load output register with fetched byte
      logic       load_err;    // load output register with an error item
      status_type err_code;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_flag;
      logic overflow;
      logic len_gt1;
      logic sum_ok;
      logic rd_last;
   } sts_type;

endpackage

@@ rtl/bsfr_ctrl.sv @@
module bsfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bsfr_pkg::sts_type sts,
   output bsfr_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      FETCH,
      SEND,
      ERR
   } state_type;

   state_type             state_ff;
   logic                  rsp_valid_ff;
   bsfr_pkg::status_type  err_code_ff;
   logic                  out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.err_code = err_code_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.take       = req_valid;
            cmd.emit_start = req_valid && sts.is_flag && !sts.overflow
                             && sts.len_gt1 && sts.sum_ok;
         end
         FETCH: begin
            cmd.fetch = 1'b1;
         end
         SEND: begin
            cmd.load_data = out_free;
            cmd.advance   = out_free && !sts.rd_last;
         end
         ERR: begin
            cmd.load_err = out_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         err_code_ff  <= bsfr_pkg::ST_GOOD;
      end else begin
         if (cmd.load_data || cmd.load_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_valid && sts.is_flag) begin
                  priority if (sts.overflow) begin
                     err_code_ff <= bsfr_pkg::ST_OVERFLOW;
                     state_ff    <= ERR;
                  end else if (sts.len_gt1 && sts.sum_ok) begin
                     state_ff <= FETCH;
                  end else if (sts.len_gt1) begin
                     err_code_ff <= bsfr_pkg::ST_BADSUM;
                     state_ff    <= ERR;
                  end else begin
                     // frame too short to check: no item
                     state_ff <= IDLE;
                  end
               end
            end
            FETCH: begin
               state_ff <= SEND;
            end
            SEND: begin
               if (out_free) begin
                  state_ff <= sts.rd_last ? IDLE : FETCH;
               end
            end
            ERR: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
         endcase
      end
   end

endmodule

@@ rtl/bsfr_dp.sv @@
module bsfr_dp #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_rx_byte,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  bsfr_pkg::cmd_type    cmd,
   output bsfr_pkg::sts_type    sts,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_last_flag,
   output logic [1:0]           rsp_frame_status
);

   localparam int IdxW = $clog2(BUFFER_DEPTH);
   localparam int LenW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [LenW-1:0] DepthLen = LenW'(BUFFER_DEPTH);

   logic [7:0]      flag_ff;
   logic [7:0]      escape_ff;
   logic [7:0]      unmask_ff;

   logic [7:0]      mem [BUFFER_DEPTH];
   logic [LenW-1:0] len_ff;
   logic            esc_ff;
   logic            ovf_ff;
   logic [7:0]      sum_ff;
   logic [7:0]      newest_ff;      // copy of the most recently stored byte

   logic [IdxW-1:0] rd_idx_ff;
   logic [IdxW-1:0] last_idx_ff;
   logic [7:0]      rd_data_ff;

   logic [7:0]      payload_ff;
   logic            last_ff;
   logic [1:0]      status_ff;

   logic            is_flag;
   logic            is_escape;
   logic            data_byte;
   logic            full;
   logic            store;
   logic [7:0]      unmasked;

   assign is_flag   = (req_rx_byte == flag_ff);
   assign is_escape = (req_rx_byte == escape_ff);
   assign data_byte = cmd.take && !is_flag && !is_escape;
   assign full      = (len_ff == DepthLen);
   assign store     = data_byte && !full;
   assign unmasked  = esc_ff ? (req_rx_byte ^ unmask_ff) : req_rx_byte;

   assign sts.is_flag  = is_flag;
   assign sts.overflow = ovf_ff;
   assign sts.len_gt1  = (len_ff > LenW'(1));
   assign sts.sum_ok   = (sum_ff == newest_ff);
   assign sts.rd_last  = (rd_idx_ff == last_idx_ff);

   assign rsp_payload_byte = payload_ff;
   assign rsp_last_flag    = last_ff;
   assign rsp_frame_status = status_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= bsfr_pkg::FLAG_RESET;
         escape_ff <= bsfr_pkg::ESCAPE_RESET;
         unmask_ff <= bsfr_pkg::UNMASK_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            bsfr_pkg::CSR_FLAG:   flag_ff   <= csr_wdata;
            bsfr_pkg::CSR_ESCAPE: escape_ff <= csr_wdata;
            bsfr_pkg::CSR_UNMASK: unmask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         esc_ff <= 1'b0;
         ovf_ff <= 1'b0;
         sum_ff <= '0;
      end else if (cmd.take) begin
         priority if (is_flag) begin
            len_ff <= '0;
            esc_ff <= 1'b0;
            ovf_ff <= 1'b0;
            sum_ff <= '0;
         end else if (is_escape) begin
            esc_ff <= 1'b1;
         end else begin
            esc_ff <= 1'b0;
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               if (len_ff != '0) begin
                  sum_ff <= sum_ff + newest_ff;
               end
               len_ff <= len_ff + LenW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         newest_ff <= unmasked;
      end
   end

   // frame buffer, registered read
   always_ff @(posedge clock) begin
      if (store) begin
         mem[len_ff[IdxW-1:0]] <= unmasked;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // read pointer; last index excludes the checksum byte
   always_ff @(posedge clock) begin
      if (cmd.emit_start) begin
         rd_idx_ff   <= '0;
         last_idx_ff <= IdxW'(len_ff - LenW'(2));
      end else if (cmd.advance) begin
         rd_idx_ff <= rd_idx_ff + IdxW'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         payload_ff <= rd_data_ff;
         last_ff    <= sts.rd_last;
         status_ff  <= bsfr_pkg::ST_GOOD;
      end else if (cmd.load_err) begin
         payload_ff <= '0;
         last_ff    <= 1'b1;
         status_ff  <= cmd.err_code;
      end
   end

endmodule

@@ rtl/byte_stuffed_frame_receiver.sv @@
// Byte-stuffed frame receiver: takes one raw link byte per req item, removes
// escapes (the byte after an escape is XORed with the unmask register), stores
// data bytes in a BUFFER_DEPTH-entry buffer and, on a flag byte, checks the last
// stored byte against the 8-bit wrapping sum of the bytes before it. A good
// frame comes out on rsp one payload byte per item, checksum byte removed, final
// byte with last set; a bad checksum gives one item with status 1, an overflowed
// frame one item with status 2 (payload 0, last 1). A flag with fewer than two
// stored bytes gives nothing. Timing: escape and data bytes are taken one per
// cycle while req_stall is low. A flag that closes a good frame holds req_stall
// high while the frame drains, each byte a registered buffer read and then an
// output register load, plus any rsp stall; an error item holds it until the
// output register is free. The output register lets the next input byte be
// taken while the final item is still waiting. Registers: 0 flag (reset 0x7E),
// 1 escape (0x7D), 2 unmask (0x20), written through csr_wen/csr_index/csr_wdata
// by the user only while no frame is draining; the block does not enforce this.
module byte_stuffed_frame_receiver #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_flag,
   output logic [1:0] rsp_frame_status,
   // register writes
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   bsfr_pkg::cmd_type cmd;
   bsfr_pkg::sts_type sts;

   // sequencing: byte intake, drain of a good frame, error item
   bsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // registers, unstuffing, checksum, buffer and output register
   bsfr_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_flag    (rsp_last_flag),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

@@ rtl/bsfr_checker.sv @@
module bsfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last_flag,
   input logic [1:0] rsp_frame_status
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // error items are last, with zero payload
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status != bsfr_pkg::ST_GOOD)
      |-> rsp_last_flag && (rsp_payload_byte == 8'd0))
      else $error("error item not last or payload nonzero");

   // input is held off while a good frame is still draining
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status == bsfr_pkg::ST_GOOD) && !rsp_last_flag
      |-> req_stall)
      else $error("input taken in the middle of a frame drain");

   // after an item without last is taken, the drain goes on or the last item is up
   a_drain_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_flag
      |=> req_stall || (rsp_valid && rsp_last_flag))
      else $error("frame drain stopped before the last byte");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (.*);
